// ----- rtl/core/process_state_list_manager_unit_assert.svh -----
// ============================================================================
// process_state_list_manager_unit_assert.svh
// assertion macros shared by the list manager rtl
// ============================================================================
`ifndef PROCESS_STATE_LIST_MANAGER_UNIT_ASSERT_SVH
`define PROCESS_STATE_LIST_MANAGER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psl assertion failed");
// next-cycle implication
`define PSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("psl assertion failed");
`else
`define PSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/psl_pkg.sv -----
// ============================================================================
// psl_pkg
// types, constants and helpers of the process state list manager
// ============================================================================
package psl_pkg;

    localparam int NUM_ENTRIES = 32;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int ID_W        = 5;
    localparam int KIND_W      = 2;
    localparam int NUM_LISTS   = 3;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [ID_W-1:0]   t_id;
    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_CREATE = 2'd0;
    localparam t_kind KIND_DELETE = 2'd1;
    localparam t_kind KIND_WAIT   = 2'd2;

    typedef enum logic [1:0] {
        LIST_FREE    = 2'd0,
        LIST_READY   = 2'd1,
        LIST_BLOCKED = 2'd2
    } t_list;

    typedef struct packed {
        logic has;
        t_idx ptr;
    } t_link;

    typedef struct packed {
        logic  en;
        t_idx  addr;
        t_link data;
    } t_link_wr;

    typedef struct packed {
        logic en;
        t_idx addr;
    } t_link_rd;

    typedef struct packed {
        t_link_rd rd;
        t_link_wr next_wr;
        t_link_wr prev_wr;
    } t_link_cmd;

    typedef struct packed {
        t_link next_q;
        t_link prev_q;
    } t_link_rsp;

    function automatic t_link next_reset(t_idx a);
        t_link l;
        l.has = (int'(a) != NUM_ENTRIES - 1);
        l.ptr = l.has ? t_idx'(int'(a) + 1) : '0;
        return l;
    endfunction

    function automatic t_link prev_reset(t_idx a);
        t_link l;
        l.has = (int'(a) != 0);
        l.ptr = l.has ? t_idx'(int'(a) - 1) : '0;
        return l;
    endfunction

    function automatic t_idx to_idx(t_id i);
        return t_idx'(i);
    endfunction

    function automatic t_id to_id(t_idx i);
        return t_id'(i);
    endfunction

endpackage

// ----- rtl/core/psl_if.sv -----
// ============================================================================
// psl_if
// request and response channels of the list manager
// ============================================================================
interface psl_req_if;
    logic           valid;
    logic           ready;
    psl_pkg::t_kind kind;
    psl_pkg::t_id   process_id;

    modport source (output valid, output kind, output process_id, input ready);
    modport sink   (input valid, input kind, input process_id, output ready);
endinterface

interface psl_rsp_if;
    logic         valid;
    logic         ready;
    logic         status;
    psl_pkg::t_id ready_head;
    logic         ready_empty;
    logic         free_empty;
    logic         blocked_empty;

    modport source (
        output valid, output status, output ready_head, output ready_empty,
        output free_empty, output blocked_empty, input ready
    );
    modport sink (
        input valid, input status, input ready_head, input ready_empty,
        input free_empty, input blocked_empty, output ready
    );
endinterface

// ----- rtl/core/process_state_list_manager_unit.sv -----
// ============================================================================
// process_state_list_manager_unit
// three doubly linked process lists (free, ready, blocked) over one entry table
// ============================================================================
// Each request moves one entry between lists: create takes it from free to
// ready, delete from ready to free, wait from ready to blocked. A request
// whose entry is not on the source list, or whose kind is unknown, returns
// status 1 and changes nothing. Link words live in two single-write-port
// memories with registered reads; a move reads the entry's links, then
// writes in the states S_READ, S_WR_TAIL and S_WR_SELF because the next-link
// memory takes up to three updates (previous neighbour, old destination tail,
// the entry itself). The block takes no new request until the current one
// has left S_DONE. The response sits in an output register, so a new
// request is taken while the last response is still waiting. After reset
// all entries are on the free list in index order; no clearing pass is
// needed.
module process_state_list_manager_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psl_req_if.sink   i_req,
    psl_rsp_if.source o_rsp
);

    psl_pkg::t_link_cmd link_cmd;
    psl_pkg::t_link_rsp link_rsp;

    psl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .o_link_cmd (link_cmd),
        .i_link_rsp (link_rsp)
    );

    psl_link_store u_link_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (link_cmd),
        .o_rsp   (link_rsp)
    );

endmodule

// ----- rtl/core/psl_ram.sv -----
// ============================================================================
// psl_ram
// simple dual port ram, one write and one registered read per cycle
// ============================================================================
module psl_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/psl_link_store.sv -----
// ============================================================================
// psl_link_store
// next and prev link memories with per-entry valid bits for reset values
// ============================================================================
module psl_link_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psl_pkg::t_link_cmd  i_cmd,
    output psl_pkg::t_link_rsp  o_rsp
);

    localparam int LW = $bits(psl_pkg::t_link);

    logic [psl_pkg::NUM_ENTRIES-1:0] r_next_vld;
    logic [psl_pkg::NUM_ENTRIES-1:0] r_prev_vld;
    logic                            r_next_hit;
    logic                            r_prev_hit;
    psl_pkg::t_idx                   r_rd_addr;
    logic [LW-1:0]                   next_q;
    logic [LW-1:0]                   prev_q;

    psl_ram #(.DEPTH(psl_pkg::NUM_ENTRIES), .WIDTH(LW)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.next_wr.en),
        .i_waddr (i_cmd.next_wr.addr),
        .i_wdata (i_cmd.next_wr.data),
        .i_re    (i_cmd.rd.en),
        .i_raddr (i_cmd.rd.addr),
        .o_rdata (next_q)
    );

    psl_ram #(.DEPTH(psl_pkg::NUM_ENTRIES), .WIDTH(LW)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.prev_wr.en),
        .i_waddr (i_cmd.prev_wr.addr),
        .i_wdata (i_cmd.prev_wr.data),
        .i_re    (i_cmd.rd.en),
        .i_raddr (i_cmd.rd.addr),
        .o_rdata (prev_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_vld <= '0;
            r_prev_vld <= '0;
        end else begin
            if (i_cmd.next_wr.en) begin
                r_next_vld[i_cmd.next_wr.addr] <= 1'b1;
            end
            if (i_cmd.prev_wr.en) begin
                r_prev_vld[i_cmd.prev_wr.addr] <= 1'b1;
            end
        end
        if (i_cmd.rd.en) begin
            r_rd_addr  <= i_cmd.rd.addr;
            r_next_hit <= r_next_vld[i_cmd.rd.addr];
            r_prev_hit <= r_prev_vld[i_cmd.rd.addr];
        end
    end

    // unwritten entries read as the free chain
    assign o_rsp.next_q = r_next_hit ? psl_pkg::t_link'(next_q)
                                     : psl_pkg::next_reset(r_rd_addr);
    assign o_rsp.prev_q = r_prev_hit ? psl_pkg::t_link'(prev_q)
                                     : psl_pkg::prev_reset(r_rd_addr);

endmodule

// ----- rtl/core/psl_ctrl.sv -----
// ============================================================================
// psl_ctrl
// request sequencer: source check, unlink, append and status response
// ============================================================================
`include "process_state_list_manager_unit_assert.svh"

module psl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    psl_req_if.sink            i_req,
    psl_rsp_if.source          o_rsp,
    output psl_pkg::t_link_cmd o_link_cmd,
    input  psl_pkg::t_link_rsp i_link_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WR_TAIL,
        S_WR_SELF,
        S_DONE
    } t_state;

    t_state                            r_state, n_state;
    psl_pkg::t_idx                     r_idx, n_idx;
    psl_pkg::t_list                    r_src, n_src;
    psl_pkg::t_list                    r_dst, n_dst;
    logic                              r_status, n_status;
    psl_pkg::t_idx                     r_tail_old, n_tail_old;
    logic                              r_dst_had, n_dst_had;
    psl_pkg::t_list                    r_member [psl_pkg::NUM_ENTRIES];
    psl_pkg::t_list                    n_member [psl_pkg::NUM_ENTRIES];
    psl_pkg::t_idx                     r_head [psl_pkg::NUM_LISTS];
    psl_pkg::t_idx                     n_head [psl_pkg::NUM_LISTS];
    psl_pkg::t_idx                     r_tail [psl_pkg::NUM_LISTS];
    psl_pkg::t_idx                     n_tail [psl_pkg::NUM_LISTS];
    logic [psl_pkg::NUM_LISTS-1:0]     r_nonempty, n_nonempty;
    logic                              r_out_valid, n_out_valid;
    logic                              r_out_status, n_out_status;
    psl_pkg::t_id                      r_out_head, n_out_head;
    logic                              r_out_ready_empty, n_out_ready_empty;
    logic                              r_out_free_empty, n_out_free_empty;
    logic                              r_out_blocked_empty, n_out_blocked_empty;

    psl_pkg::t_idx                 tail_init [psl_pkg::NUM_LISTS];
    logic [psl_pkg::NUM_LISTS-1:0] nonempty_init;

    psl_pkg::t_idx  req_idx;
    psl_pkg::t_list req_src;
    psl_pkg::t_list req_dst;
    logic           req_kind_ok;
    logic           req_ok;
    logic           req_accept;
    psl_pkg::t_link e_next;
    psl_pkg::t_link e_prev;

    assign req_idx    = psl_pkg::to_idx(i_req.process_id);
    assign req_accept = i_req.valid && i_req.ready;
    assign e_next     = i_link_rsp.next_q;
    assign e_prev     = i_link_rsp.prev_q;

    // reset view: only the free list holds entries, tail at the last index
    always_comb begin
        tail_init                         = '{default: '0};
        tail_init[psl_pkg::LIST_FREE]     = psl_pkg::t_idx'(psl_pkg::NUM_ENTRIES - 1);
        nonempty_init                     = '0;
        nonempty_init[psl_pkg::LIST_FREE] = 1'b1;
    end

    always_comb begin
        req_src     = psl_pkg::LIST_FREE;
        req_dst     = psl_pkg::LIST_READY;
        req_kind_ok = 1'b1;
        unique case (i_req.kind)
            psl_pkg::KIND_CREATE: begin
                req_src = psl_pkg::LIST_FREE;
                req_dst = psl_pkg::LIST_READY;
            end
            psl_pkg::KIND_DELETE: begin
                req_src = psl_pkg::LIST_READY;
                req_dst = psl_pkg::LIST_FREE;
            end
            psl_pkg::KIND_WAIT: begin
                req_src = psl_pkg::LIST_READY;
                req_dst = psl_pkg::LIST_BLOCKED;
            end
            default: begin
                req_kind_ok = 1'b0;
            end
        endcase
        req_ok = req_kind_ok
              && (int'(i_req.process_id) < psl_pkg::NUM_ENTRIES)
              && (r_member[req_idx] == req_src);
    end

    always_comb begin
        n_state             = r_state;
        n_idx               = r_idx;
        n_src               = r_src;
        n_dst               = r_dst;
        n_status            = r_status;
        n_tail_old          = r_tail_old;
        n_dst_had           = r_dst_had;
        n_member            = r_member;
        n_head              = r_head;
        n_tail              = r_tail;
        n_nonempty          = r_nonempty;
        n_out_valid         = r_out_valid;
        n_out_status        = r_out_status;
        n_out_head          = r_out_head;
        n_out_ready_empty   = r_out_ready_empty;
        n_out_free_empty    = r_out_free_empty;
        n_out_blocked_empty = r_out_blocked_empty;
        o_link_cmd          = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_idx = req_idx;
                    n_src = req_src;
                    n_dst = req_dst;
                    if (req_ok) begin
                        o_link_cmd.rd.en   = 1'b1;
                        o_link_cmd.rd.addr = req_idx;
                        n_status           = 1'b0;
                        n_state            = S_READ;
                    end else begin
                        n_status = 1'b1;
                        n_state  = S_DONE;
                    end
                end
            end
            S_READ: begin
                // unlink: fix neighbours
                o_link_cmd.next_wr.en   = e_prev.has;
                o_link_cmd.next_wr.addr = e_prev.ptr;
                o_link_cmd.next_wr.data = e_next;
                o_link_cmd.prev_wr.en   = e_next.has;
                o_link_cmd.prev_wr.addr = e_next.ptr;
                o_link_cmd.prev_wr.data = e_prev;
                if (!e_prev.has) begin
                    n_head[r_src] = e_next.has ? e_next.ptr : '0;
                end
                if (!e_next.has) begin
                    n_tail[r_src] = e_prev.has ? e_prev.ptr : '0;
                end
                if (!e_prev.has && !e_next.has) begin
                    n_nonempty[r_src] = 1'b0;
                end
                // append at destination tail
                n_tail_old = r_tail[r_dst];
                n_dst_had  = r_nonempty[r_dst];
                if (!r_nonempty[r_dst]) begin
                    n_head[r_dst] = r_idx;
                end
                n_tail[r_dst]     = r_idx;
                n_nonempty[r_dst] = 1'b1;
                n_member[r_idx]   = r_dst;
                n_state           = S_WR_TAIL;
            end
            S_WR_TAIL: begin
                o_link_cmd.next_wr.en       = r_dst_had;
                o_link_cmd.next_wr.addr     = r_tail_old;
                o_link_cmd.next_wr.data.has = 1'b1;
                o_link_cmd.next_wr.data.ptr = r_idx;
                o_link_cmd.prev_wr.en       = 1'b1;
                o_link_cmd.prev_wr.addr     = r_idx;
                o_link_cmd.prev_wr.data.has = r_dst_had;
                o_link_cmd.prev_wr.data.ptr = r_dst_had ? r_tail_old : '0;
                n_state                     = S_WR_SELF;
            end
            S_WR_SELF: begin
                o_link_cmd.next_wr.en   = 1'b1;
                o_link_cmd.next_wr.addr = r_idx;
                o_link_cmd.next_wr.data = '0;
                n_state                 = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid         = 1'b1;
                    n_out_status        = r_status;
                    n_out_head          = r_nonempty[psl_pkg::LIST_READY]
                                        ? psl_pkg::to_id(r_head[psl_pkg::LIST_READY]) : '0;
                    n_out_ready_empty   = !r_nonempty[psl_pkg::LIST_READY];
                    n_out_free_empty    = !r_nonempty[psl_pkg::LIST_FREE];
                    n_out_blocked_empty = !r_nonempty[psl_pkg::LIST_BLOCKED];
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_member    <= '{default: psl_pkg::LIST_FREE};
            r_head      <= '{default: '0};
            r_tail      <= tail_init;
            r_nonempty  <= nonempty_init;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_member    <= n_member;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_nonempty  <= n_nonempty;
        end
        r_idx               <= n_idx;
        r_src               <= n_src;
        r_dst               <= n_dst;
        r_status            <= n_status;
        r_tail_old          <= n_tail_old;
        r_dst_had           <= n_dst_had;
        r_out_status        <= n_out_status;
        r_out_head          <= n_out_head;
        r_out_ready_empty   <= n_out_ready_empty;
        r_out_free_empty    <= n_out_free_empty;
        r_out_blocked_empty <= n_out_blocked_empty;
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.ready_head    = r_out_head;
    assign o_rsp.ready_empty   = r_out_ready_empty;
    assign o_rsp.free_empty    = r_out_free_empty;
    assign o_rsp.blocked_empty = r_out_blocked_empty;

    // at least one list is always non-empty
    `PSL_ASSERT_IMP(a_some_list_nonempty, i_clk, i_rst_n, 1'b1, (r_nonempty != '0))
    // an empty ready list keeps zero head and tail
    `PSL_ASSERT_IMP(a_ready_empty_ptrs, i_clk, i_rst_n,
        !r_nonempty[psl_pkg::LIST_READY],
        (r_head[psl_pkg::LIST_READY] == '0) && (r_tail[psl_pkg::LIST_READY] == '0))
    // refused request goes straight to the response
    `PSL_ASSERT_NXT(a_refuse_to_done, i_clk, i_rst_n, req_accept && !req_ok,
        (r_state == S_DONE) && r_status)
    // link writes only for a request that passed the source check
    `PSL_ASSERT_IMP(a_write_ok_only, i_clk, i_rst_n,
        o_link_cmd.next_wr.en || o_link_cmd.prev_wr.en, !r_status)

endmodule
